// File: rtl/tfws_pkg.sv
package tfws_pkg;

    localparam int COORD_W  = 24;
    localparam int VALUE_W  = 24;
    localparam int TYPE_W   = 6;
    localparam int MASK_W   = 64;
    localparam int AXIS_W   = 2;
    localparam int START_W  = 16;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 64;
    localparam int ACT_W    = 2;
    localparam int KIND_W   = 2;
    localparam int CNT_W    = 17;
    localparam int CSUM_W   = 41;
    localparam int SQSUM_W  = 64;
    localparam int WSUM_W   = 40;
    localparam int FIDX_W   = 32;
    localparam int DIV_W    = 64;
    localparam int SQOP_W   = 48;
    localparam int SQREM_W  = 26;
    localparam int STEP_W   = 6;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DIV_W - 1);
    localparam logic [STEP_W-1:0] SQ_STEPS  = STEP_W'(VALUE_W - 1);

    localparam logic [ACT_W-1:0] ACT_PARTICLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FRAME    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_WIDTH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEAN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEV   = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_TYPE_MASK   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_AXIS        = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_START_FRAME = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE       = 4'd0;
    localparam t_op OP_PLATCH     = 4'd1;
    localparam t_op OP_PACC       = 4'd2;
    localparam t_op OP_FCLR       = 4'd3;
    localparam t_op OP_LOAD_FRAME = 4'd4;
    localparam t_op OP_LOAD_FIN   = 4'd5;
    localparam t_op OP_DIV_STEP   = 4'd6;
    localparam t_op OP_DIVB_START = 4'd7;
    localparam t_op OP_MULT       = 4'd8;
    localparam t_op OP_SQ_START   = 4'd9;
    localparam t_op OP_SQ_STEP    = 4'd10;
    localparam t_op OP_FRAME_DONE = 4'd11;
    localparam t_op OP_OUT_MEAN   = 4'd12;
    localparam t_op OP_OUT_DEV    = 4'd13;

    typedef struct packed {
        logic frame_ge;
        logic frame_nz;
        logic fin_nz;
        logic fin;
        logic step_last;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/tfws_ctrl.sv
module tfws_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [tfws_pkg::ACT_W-1:0]  i_action,
    input  tfws_pkg::t_stat             i_stat,
    output logic                        o_in_ready,
    output tfws_pkg::t_op               o_op
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PACC  = 4'd1;
    localparam logic [3:0] S_DIVA  = 4'd2;
    localparam logic [3:0] S_DIVB0 = 4'd3;
    localparam logic [3:0] S_DIVB  = 4'd4;
    localparam logic [3:0] S_MULT  = 4'd5;
    localparam logic [3:0] S_SQ0   = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_FPOST = 4'd8;
    localparam logic [3:0] S_OUTM  = 4'd9;
    localparam logic [3:0] S_OUTD  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = tfws_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        tfws_pkg::ACT_PARTICLE: begin
                            o_op    = tfws_pkg::OP_PLATCH;
                            n_state = S_PACC;
                        end
                        tfws_pkg::ACT_FRAME: begin
                            if (!i_stat.frame_ge) begin
                                o_op = tfws_pkg::OP_FCLR;
                            end else begin
                                o_op    = tfws_pkg::OP_LOAD_FRAME;
                                n_state = i_stat.frame_nz ? S_DIVA : S_FPOST;
                            end
                        end
                        tfws_pkg::ACT_FINISH: begin
                            o_op    = tfws_pkg::OP_LOAD_FIN;
                            n_state = i_stat.fin_nz ? S_DIVA : S_OUTM;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PACC: begin
                o_op    = tfws_pkg::OP_PACC;
                n_state = S_IDLE;
            end
            S_DIVA: begin
                o_op = tfws_pkg::OP_DIV_STEP;
                if (i_stat.step_last) n_state = S_DIVB0;
            end
            S_DIVB0: begin
                o_op    = tfws_pkg::OP_DIVB_START;
                n_state = S_DIVB;
            end
            S_DIVB: begin
                o_op = tfws_pkg::OP_DIV_STEP;
                if (i_stat.step_last) n_state = S_MULT;
            end
            S_MULT: begin
                o_op    = tfws_pkg::OP_MULT;
                n_state = S_SQ0;
            end
            S_SQ0: begin
                o_op    = tfws_pkg::OP_SQ_START;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_op = tfws_pkg::OP_SQ_STEP;
                if (i_stat.step_last) n_state = i_stat.fin ? S_OUTM : S_FPOST;
            end
            S_FPOST: begin
                if (i_stat.out_free) begin
                    o_op    = tfws_pkg::OP_FRAME_DONE;
                    n_state = S_IDLE;
                end
            end
            S_OUTM: begin
                if (i_stat.out_free) begin
                    o_op    = tfws_pkg::OP_OUT_MEAN;
                    n_state = S_OUTD;
                end
            end
            S_OUTD: begin
                if (i_stat.out_free) begin
                    o_op    = tfws_pkg::OP_OUT_DEV;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/tfws_dp.sv
module tfws_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tfws_pkg::t_op                 i_op,
    output tfws_pkg::t_stat               o_stat,
    input  logic                          i_cfg_valid,
    input  logic [tfws_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [tfws_pkg::CDATA_W-1:0]  i_cfg_data,
    input  logic [tfws_pkg::TYPE_W-1:0]   i_particle_type,
    input  logic [tfws_pkg::COORD_W-1:0]  i_pos_x,
    input  logic [tfws_pkg::COORD_W-1:0]  i_pos_y,
    input  logic [tfws_pkg::COORD_W-1:0]  i_pos_z,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tfws_pkg::KIND_W-1:0]   o_result_kind,
    output logic [tfws_pkg::VALUE_W-1:0]  o_value,
    output logic                          o_last
);

    logic [tfws_pkg::MASK_W-1:0]   r_type_mask;
    logic [tfws_pkg::AXIS_W-1:0]   r_axis;
    logic [tfws_pkg::START_W-1:0]  r_start_frame;

    logic [tfws_pkg::FIDX_W-1:0]   r_frame_index;
    logic signed [tfws_pkg::CSUM_W-1:0] r_coord_sum;
    logic [tfws_pkg::SQSUM_W-1:0]  r_coord_sq_sum;
    logic [tfws_pkg::CNT_W-1:0]    r_match_count;
    logic [tfws_pkg::WSUM_W-1:0]   r_width_sum;
    logic [tfws_pkg::SQSUM_W-1:0]  r_width_sq_sum;
    logic [tfws_pkg::CNT_W-1:0]    r_frames_counted;

    logic                          r_hit;
    logic [tfws_pkg::COORD_W-1:0]  r_c;
    logic [tfws_pkg::COORD_W-1:0]  r_mag;
    logic                          r_fin;
    logic [tfws_pkg::CNT_W-1:0]    r_div_n;
    logic [tfws_pkg::DIV_W-1:0]    r_quo;
    logic [tfws_pkg::CNT_W-1:0]    r_rem;
    logic [tfws_pkg::STEP_W-1:0]   r_step;
    logic [tfws_pkg::VALUE_W-1:0]  r_mean;
    logic [tfws_pkg::SQOP_W-1:0]   r_msq;
    logic [tfws_pkg::SQOP_W-1:0]   r_msqm;
    logic [tfws_pkg::SQOP_W-1:0]   r_sq_op;
    logic [tfws_pkg::SQREM_W-1:0]  r_sq_rem;
    logic [tfws_pkg::VALUE_W-1:0]  r_root;

    logic                          r_out_valid;
    logic [tfws_pkg::KIND_W-1:0]   r_out_kind;
    logic [tfws_pkg::VALUE_W-1:0]  r_out_value;
    logic                          r_out_last;

    logic [tfws_pkg::COORD_W-1:0]  n_c;
    logic [tfws_pkg::CSUM_W-1:0]   n_abs_sum;
    logic [tfws_pkg::CNT_W:0]      n_div_t;
    logic [tfws_pkg::CNT_W:0]      n_div_d;
    logic [tfws_pkg::SQREM_W+1:0]  n_sq_t;
    logic [tfws_pkg::SQREM_W+1:0]  n_sq_trial;
    logic [tfws_pkg::FIDX_W-1:0]   n_frame_index;
    logic [tfws_pkg::SQOP_W-1:0]   n_mag_sq;
    logic [tfws_pkg::SQOP_W-1:0]   n_root_sq;
    logic                          w_out_load;

    always_comb begin
        case (r_axis)
            tfws_pkg::AXIS_X: n_c = i_pos_x;
            tfws_pkg::AXIS_Y: n_c = i_pos_y;
            default:          n_c = i_pos_z;
        endcase
        n_abs_sum = r_coord_sum[tfws_pkg::CSUM_W-1] ? 
                    tfws_pkg::CSUM_W'(-r_coord_sum) : r_coord_sum;
        n_div_t    = {r_rem, r_quo[tfws_pkg::DIV_W-1]};
        n_div_d    = {1'b0, r_div_n};
        n_sq_t     = {r_sq_rem, r_sq_op[tfws_pkg::SQOP_W-1 -: 2]};
        n_sq_trial = {2'b00, r_root, 2'b01};
        n_frame_index = (&r_frame_index) ? r_frame_index : r_frame_index + 1'b1;
        n_mag_sq   = r_mag * r_mag;
        n_root_sq  = r_root * r_root;
        w_out_load = i_op inside {tfws_pkg::OP_FRAME_DONE, tfws_pkg::OP_OUT_MEAN,
                                  tfws_pkg::OP_OUT_DEV};
    end

    assign o_stat.frame_ge  = (r_frame_index >= {16'd0, r_start_frame});
    assign o_stat.frame_nz  = (r_match_count != '0);
    assign o_stat.fin_nz    = (r_frames_counted != '0);
    assign o_stat.fin       = r_fin;
    assign o_stat.step_last = (r_step == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_value       = r_out_value;
    assign o_last        = r_out_last;

    // payload and arithmetic working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            tfws_pkg::OP_PLATCH: begin
                r_hit <= r_type_mask[i_particle_type] && !r_match_count[tfws_pkg::CNT_W-1];
                r_c   <= n_c;
                r_mag <= n_c[tfws_pkg::COORD_W-1] ? (~n_c + 1'b1) : n_c;
            end
            tfws_pkg::OP_LOAD_FRAME: begin
                r_div_n <= r_match_count;
                r_quo   <= tfws_pkg::DIV_W'(n_abs_sum);
                r_rem   <= '0;
                r_step  <= tfws_pkg::DIV_STEPS;
                r_mean  <= '0;
                r_root  <= '0;
            end
            tfws_pkg::OP_LOAD_FIN: begin
                r_div_n <= r_frames_counted;
                r_quo   <= tfws_pkg::DIV_W'(r_width_sum);
                r_rem   <= '0;
                r_step  <= tfws_pkg::DIV_STEPS;
                r_mean  <= '0;
                r_root  <= '0;
            end
            tfws_pkg::OP_DIV_STEP: begin
                if (n_div_t >= n_div_d) begin
                    r_rem <= tfws_pkg::CNT_W'(n_div_t - n_div_d);
                    r_quo <= {r_quo[tfws_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_div_t[tfws_pkg::CNT_W-1:0];
                    r_quo <= {r_quo[tfws_pkg::DIV_W-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
            end
            tfws_pkg::OP_DIVB_START: begin
                r_mean <= r_quo[tfws_pkg::VALUE_W-1:0];
                r_quo  <= r_fin ? r_width_sq_sum : r_coord_sq_sum;
                r_rem  <= '0;
                r_step <= tfws_pkg::DIV_STEPS;
            end
            tfws_pkg::OP_MULT: begin
                r_msq  <= r_quo[tfws_pkg::SQOP_W-1:0];
                r_msqm <= r_mean * r_mean;
            end
            tfws_pkg::OP_SQ_START: begin
                r_sq_op  <= (r_msq > r_msqm) ? r_msq - r_msqm : '0;
                r_sq_rem <= '0;
                r_root   <= '0;
                r_step   <= tfws_pkg::SQ_STEPS;
            end
            tfws_pkg::OP_SQ_STEP: begin
                if (n_sq_t >= n_sq_trial) begin
                    r_sq_rem <= tfws_pkg::SQREM_W'(n_sq_t - n_sq_trial);
                    r_root   <= {r_root[tfws_pkg::VALUE_W-2:0], 1'b1};
                end else begin
                    r_sq_rem <= n_sq_t[tfws_pkg::SQREM_W-1:0];
                    r_root   <= {r_root[tfws_pkg::VALUE_W-2:0], 1'b0};
                end
                r_sq_op <= {r_sq_op[tfws_pkg::SQOP_W-3:0], 2'b00};
                r_step  <= r_step - 1'b1;
            end
            tfws_pkg::OP_FRAME_DONE: begin
                r_out_kind  <= tfws_pkg::KIND_WIDTH;
                r_out_value <= r_root;
                r_out_last  <= 1'b1;
            end
            tfws_pkg::OP_OUT_MEAN: begin
                r_out_kind  <= tfws_pkg::KIND_MEAN;
                r_out_value <= r_mean;
                r_out_last  <= 1'b0;
            end
            tfws_pkg::OP_OUT_DEV: begin
                r_out_kind  <= tfws_pkg::KIND_DEV;
                r_out_value <= r_root;
                r_out_last  <= 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // configuration, accumulators and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_mask      <= '0;
            r_axis           <= '0;
            r_start_frame    <= '0;
            r_frame_index    <= '0;
            r_coord_sum      <= '0;
            r_coord_sq_sum   <= '0;
            r_match_count    <= '0;
            r_width_sum      <= '0;
            r_width_sq_sum   <= '0;
            r_frames_counted <= '0;
            r_fin            <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tfws_pkg::CFG_TYPE_MASK:   r_type_mask   <= i_cfg_data;
                    tfws_pkg::CFG_AXIS:        r_axis        <= i_cfg_data[tfws_pkg::AXIS_W-1:0];
                    tfws_pkg::CFG_START_FRAME: r_start_frame <= i_cfg_data[tfws_pkg::START_W-1:0];
                    default:                   r_axis        <= r_axis;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                tfws_pkg::OP_PACC: begin
                    if (r_hit) begin
                        r_coord_sum    <= r_coord_sum + tfws_pkg::CSUM_W'(signed'(r_c));
                        r_coord_sq_sum <= r_coord_sq_sum + tfws_pkg::SQSUM_W'(n_mag_sq);
                        r_match_count  <= r_match_count + 1'b1;
                    end
                end
                tfws_pkg::OP_FCLR: begin
                    r_coord_sum    <= '0;
                    r_coord_sq_sum <= '0;
                    r_match_count  <= '0;
                    r_frame_index  <= n_frame_index;
                end
                tfws_pkg::OP_LOAD_FRAME: r_fin <= 1'b0;
                tfws_pkg::OP_LOAD_FIN:   r_fin <= 1'b1;
                tfws_pkg::OP_FRAME_DONE: begin
                    if (!r_frames_counted[tfws_pkg::CNT_W-1]) begin
                        r_width_sum      <= r_width_sum + tfws_pkg::WSUM_W'(r_root);
                        r_width_sq_sum   <= r_width_sq_sum
                                            + tfws_pkg::SQSUM_W'(n_root_sq);
                        r_frames_counted <= r_frames_counted + 1'b1;
                    end
                    r_coord_sum    <= '0;
                    r_coord_sq_sum <= '0;
                    r_match_count  <= '0;
                    r_frame_index  <= n_frame_index;
                end
                tfws_pkg::OP_OUT_DEV: begin
                    r_frame_index    <= '0;
                    r_coord_sum      <= '0;
                    r_coord_sq_sum   <= '0;
                    r_match_count    <= '0;
                    r_width_sum      <= '0;
                    r_width_sq_sum   <= '0;
                    r_frames_counted <= '0;
                end
                default: begin
                    r_fin <= r_fin;
                end
            endcase
        end
    end

endmodule

// File: rtl/type_filtered_width_statistics.sv
// Particle word: accepted, then accumulated on the next edge; the next word waits for it.
// End of frame with counted particles: two 64-step divides, one multiply and a 24-step
// square root, then the width word. Finish: the same on the frame widths, then the mean
// word and the deviation word. Empty frames, skipped frames and empty finishes skip the
// arithmetic; a stalled output adds its wait before the next word. Synchronous active-low
// reset clears state, config, sums, counters and output valid, not the working registers.
module type_filtered_width_statistics (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [5:0]                    i_particle_type,
    input  logic signed [23:0]            i_pos_x,
    input  logic signed [23:0]            i_pos_y,
    input  logic signed [23:0]            i_pos_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_result_kind,
    output logic [23:0]                   o_value,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    tfws_pkg::t_op   w_op;
    tfws_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    tfws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_op       (w_op)
    );

    tfws_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_particle_type (i_particle_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_value         (o_value),
        .o_last          (o_last)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [tfws_pkg::ACT_W-1:0]  ACT_IGNORED  = 2'd3;
    localparam logic [tfws_pkg::AXIS_W-1:0] AXIS_Z       = 2'd2;
    localparam logic [tfws_pkg::AXIS_W-1:0] AXIS_Z_ALIAS = 2'd3;

    typedef struct packed {
        logic [tfws_pkg::ACT_W-1:0]   action;
        logic [tfws_pkg::TYPE_W-1:0]  ptype;
        logic [tfws_pkg::COORD_W-1:0] px;
        logic [tfws_pkg::COORD_W-1:0] py;
        logic [tfws_pkg::COORD_W-1:0] pz;
    } t_word;

    typedef struct packed {
        logic [tfws_pkg::KIND_W-1:0]  kind;
        logic [tfws_pkg::VALUE_W-1:0] value;
        logic                         last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_action = '0;
    logic [5:0] i_particle_type = '0;
    logic signed [23:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_result_kind;
    logic [23:0] o_value;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    type_filtered_width_statistics uut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [63:0] m_mask;
    logic [1:0]  m_axis;
    logic [15:0] m_start;
    logic [31:0] p_fidx;
    longint      p_csum;
    logic [63:0] p_sqsum;
    int unsigned p_cnt;
    logic [63:0] p_wsum, p_wsq;
    int unsigned p_frames;

    t_word pending_words[$];
    t_res  expected_results[$];
    int    errors = 0;
    int    gap_left = 0;
    int    burst_left = 0;
    bit    feeding = 1'b0;
    t_word cur_word;
    bit    taken;

    task automatic queue_word(t_word w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic queue_result(t_res r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] spread_of(logic [63:0] a, logic [63:0] sq, logic [63:0] n);
        logic [63:0] mn, msq;
        if (n == 0) return 0;
        mn = a / n;
        msq = sq / n;
        if (msq <= mn * mn) return 0;
        return int_sqrt(msq - mn * mn);
    endfunction

    task automatic clear_sums();
        p_fidx = 0; p_csum = 0; p_sqsum = 0; p_cnt = 0;
        p_wsum = 0; p_wsq = 0; p_frames = 0;
    endtask

    task automatic predict_word(t_word w);
        longint c;
        logic [63:0] mag, wd, a;
        t_res r;
        case (w.action)
            tfws_pkg::ACT_PARTICLE: begin
                if (m_mask[w.ptype] && p_cnt < 65536) begin
                    c = (m_axis == tfws_pkg::AXIS_X) ? longint'($signed(w.px)) :
                        (m_axis == tfws_pkg::AXIS_Y) ? longint'($signed(w.py)) :
                        longint'($signed(w.pz));
                    mag = c < 0 ? -c : c;
                    p_csum += c;
                    p_sqsum += mag * mag;
                    p_cnt++;
                end
            end
            tfws_pkg::ACT_FRAME: begin
                if (p_fidx >= {16'd0, m_start}) begin
                    a = p_csum < 0 ? -p_csum : p_csum;
                    wd = spread_of(a, p_sqsum, 64'(p_cnt)) & 64'hFFFFFF;
                    if (p_frames < 65536) begin
                        p_wsum += wd; p_wsq += wd * wd; p_frames++;
                    end
                    r.kind = tfws_pkg::KIND_WIDTH; r.value = wd[23:0]; r.last = 1'b1;
                    queue_result(r);
                end
                p_csum = 0; p_sqsum = 0; p_cnt = 0;
                if (p_fidx != 32'hFFFF_FFFF) p_fidx++;
            end
            tfws_pkg::ACT_FINISH: begin
                r.kind = tfws_pkg::KIND_MEAN; r.last = 1'b0;
                r.value = (p_frames != 0) ? 24'(p_wsum / p_frames) : '0;
                queue_result(r);
                r.kind = tfws_pkg::KIND_DEV; r.last = 1'b1;
                r.value = 24'(spread_of(p_wsum, p_wsq, 64'(p_frames)));
                queue_result(r);
                clear_sums();
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        taken <= i_in_valid && o_in_ready;
    end

    always @(negedge i_clk) begin
        if (taken) begin
            predict_word(cur_word);
        end
        if (!i_in_valid || taken) begin
            if (feeding && pending_words.size() > 0 && gap_left == 0) begin
                cur_word = pending_words.pop_front();
                i_action <= cur_word.action;
                i_particle_type <= cur_word.ptype;
                i_pos_x <= cur_word.px;
                i_pos_y <= cur_word.py;
                i_pos_z <= cur_word.pz;
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver stall pattern and monitor
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        i_out_ready <= ((stall_phase / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: expected none, got kind=%0d value=%h last=%0d",
                         $time, o_result_kind, o_value, o_last);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.kind !== o_result_kind || e.value !== o_value || e.last !== o_last) begin
                    $display("%0t: mismatch expected kind=%0d value=%h last=%0d, %s",
                             $time, e.kind, e.value, e.last, "got");
                    $display("%0t:          actual kind=%0d value=%h last=%0d",
                             $time, o_result_kind, o_value, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            tfws_pkg::CFG_TYPE_MASK:   m_mask = data;
            tfws_pkg::CFG_AXIS:        m_axis = data[1:0];
            tfws_pkg::CFG_START_FRAME: m_start = data[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 8000)) - 4000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_word make_word(logic [1:0] act, logic [5:0] t);
        t_word w;
        w.action = act; w.ptype = t;
        w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
        return w;
    endfunction

    task automatic run_phase(int n_items);
        int i, left;
        logic [1:0] act;
        left = n_items;
        while (left > 0) begin
            i = $urandom_range(0, 12);
            repeat (i) begin
                queue_word(make_word(tfws_pkg::ACT_PARTICLE, 6'($urandom)));
                left--;
            end
            act = ($urandom_range(0, 15) == 0) ? ACT_IGNORED :
                  ($urandom_range(0, 9) == 0) ? tfws_pkg::ACT_FINISH : tfws_pkg::ACT_FRAME;
            queue_word(make_word(act, 6'($urandom)));
            left--;
        end
        queue_word(make_word(tfws_pkg::ACT_FINISH, '0));
        feeding = 1'b1;
        while (pending_words.size() > 0 || i_in_valid || taken) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin
        t_word w;
        m_mask = 0; m_axis = 0; m_start = 0;
        clear_sums();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, empty frame, empty finish, ignored action
        queue_word(make_word(tfws_pkg::ACT_FINISH, '0));
        queue_word(make_word(tfws_pkg::ACT_FRAME, '0));
        queue_word(make_word(ACT_IGNORED, '0));
        queue_word(make_word(tfws_pkg::ACT_FINISH, '0));
        feeding = 1'b1;
        while (pending_words.size() > 0 || i_in_valid || taken) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        feeding = 1'b0;

        write_reg(tfws_pkg::CFG_TYPE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(tfws_pkg::CFG_AXIS, 64'(AXIS_Z_ALIAS));
        write_reg(tfws_pkg::CFG_START_FRAME, 64'd0);
        w = make_word(tfws_pkg::ACT_PARTICLE, 6'd63);
        w.px = 24'h7FFFFF; w.py = 24'h800000; w.pz = 24'h800000;
        queue_word(w);
        w.pz = 24'h7FFFFF;
        queue_word(w);
        queue_word(make_word(tfws_pkg::ACT_FRAME, '0));
        for (int k = 0; k < 6; k++) queue_word(make_word(tfws_pkg::ACT_PARTICLE, 6'(k)));
        queue_word(make_word(tfws_pkg::ACT_FRAME, '0));
        run_phase(10);
        feeding = 1'b0;

        write_reg(tfws_pkg::CFG_AXIS, 64'(tfws_pkg::AXIS_X));
        write_reg(tfws_pkg::CFG_TYPE_MASK, {$urandom, $urandom});
        run_phase(400);
        feeding = 1'b0;
        write_reg(tfws_pkg::CFG_AXIS, 64'(tfws_pkg::AXIS_Y));
        write_reg(tfws_pkg::CFG_START_FRAME, 64'd3);
        run_phase(400);
        feeding = 1'b0;
        write_reg(tfws_pkg::CFG_AXIS, 64'(AXIS_Z));
        write_reg(tfws_pkg::CFG_TYPE_MASK, 64'h1);
        write_reg(tfws_pkg::CFG_START_FRAME, 64'hFFFF);
        run_phase(150);
        feeding = 1'b0;
        write_reg(tfws_pkg::CFG_TYPE_MASK, 64'h8000_0000_0000_0001 | {$urandom, $urandom});
        write_reg(tfws_pkg::CFG_START_FRAME, 64'd0);
        run_phase(700);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
